// ===== hw/rtl/aup_pkg.sv =====
// Shared types and constants for the alpha un-premultiply unit.
package aup_pkg;

  localparam int CHAN_W      = 8;
  localparam int NUM_CHAN    = 3;
  localparam int NUM_W       = 17;
  localparam int QUO_W       = 8;
  localparam int MID_DEPTH_DEF = 2;
  localparam int OUT_DEPTH_DEF = 2;

  localparam logic APOS_TRAILING = 1'b0;
  localparam logic APOS_LEADING  = 1'b1;

  typedef struct packed {
    logic                                  apos;
    logic [CHAN_W-1:0]                     alpha;
    logic                                  azero;
    logic [NUM_CHAN-1:0]                   clip;
    logic [NUM_CHAN-1:0][NUM_W-1:0]        num;
  } aup_mid_t;

  typedef struct packed {
    logic                                  apos;
    logic [CHAN_W-1:0]                     alpha;
    logic                                  azero;
    logic [NUM_CHAN-1:0]                   clip;
    logic [NUM_CHAN-1:0][NUM_W-1:0]        rem;
    logic [NUM_CHAN-1:0][QUO_W-1:0]        quo;
  } aup_work_t;

  typedef struct packed {
    logic [31:0] pixel;
    logic        clipped;
  } aup_res_t;

endpackage

// ===== hw/rtl/aup_queue.sv =====
// Small register-based first-in first-out queue.
module aup_queue #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/aup_front.sv =====
// Front end: splits a pixel into alpha and colors and classifies each color.
module aup_front import aup_pkg::*; (
  input  logic [31:0] pixel,
  input  logic        apos,
  output aup_mid_t    item
);

  logic [CHAN_W-1:0] alpha;
  logic [CHAN_W-1:0] color [NUM_CHAN];

  always_comb begin
    alpha = (apos == APOS_LEADING) ? pixel[31:24] : pixel[7:0];
    for (int j = 0; j < NUM_CHAN; j++) begin
      color[j] = (apos == APOS_LEADING) ? pixel[j*CHAN_W +: CHAN_W]
                                        : pixel[(j+1)*CHAN_W +: CHAN_W];
    end
  end

  always_comb begin
    item.apos  = apos;
    item.alpha = alpha;
    item.azero = (alpha == '0);
    for (int j = 0; j < NUM_CHAN; j++) begin
      item.num[j] = {color[j], 9'd0} - {8'd0, color[j], 1'b0} + {9'd0, alpha};
      if (alpha == '0) begin
        item.clip[j] = (color[j] != '0);
      end else begin
        item.clip[j] = (item.num[j] >= {alpha, 9'd0});
      end
    end
  end

endmodule

// ===== hw/rtl/aup_back.sv =====
// Back end: pipelined restoring divider, one quotient bit per stage.
module aup_back import aup_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  aup_mid_t mid_data,
  input  logic     mid_empty,
  output logic     mid_pop,
  output aup_res_t res_data,
  output logic     res_push,
  input  logic     res_full
);

  localparam int STAGES = QUO_W;

  aup_work_t         stg_r   [STAGES];
  aup_work_t         stg_in  [STAGES];
  aup_work_t         stg_nxt [STAGES];
  logic [STAGES-1:0] vld_r;
  logic              en;
  logic [CHAN_W-1:0] val [NUM_CHAN];
  aup_work_t         last;

  assign en      = !vld_r[STAGES-1] || !res_full;
  assign mid_pop = en && !mid_empty;

  always_comb begin
    stg_in[0].apos  = mid_data.apos;
    stg_in[0].alpha = mid_data.alpha;
    stg_in[0].azero = mid_data.azero;
    stg_in[0].clip  = mid_data.clip;
    stg_in[0].rem   = mid_data.num;
    stg_in[0].quo   = '0;
  end

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    localparam int BITPOS = STAGES - 1 - k;
    if (k > 0) begin : g_link
      assign stg_in[k] = stg_r[k-1];
    end

    always_comb begin
      logic [NUM_W-1:0] sub;
      stg_nxt[k] = stg_in[k];
      for (int j = 0; j < NUM_CHAN; j++) begin
        sub = {8'd0, stg_in[k].alpha, 1'b0} << BITPOS;
        if (stg_in[k].rem[j] >= sub) begin
          stg_nxt[k].rem[j]         = stg_in[k].rem[j] - sub;
          stg_nxt[k].quo[j][BITPOS] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[STAGES-2:0], !mid_empty};
    end
  end

  assign last = stg_r[STAGES-1];

  always_comb begin
    for (int j = 0; j < NUM_CHAN; j++) begin
      if (last.clip[j]) begin
        val[j] = '1;
      end else if (last.azero) begin
        val[j] = '0;
      end else begin
        val[j] = last.quo[j];
      end
    end
    if (last.apos == APOS_LEADING) begin
      res_data.pixel = {last.alpha, val[2], val[1], val[0]};
    end else begin
      res_data.pixel = {val[2], val[1], val[0], last.alpha};
    end
    res_data.clipped = |last.clip;
  end

  assign res_push = en && vld_r[STAGES-1];

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline moved while stalled");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !en |-> (vld_r[STAGES-1] && res_full && !mid_pop))
    else $error("stall without a blocked result");

endmodule

// ===== hw/rtl/alpha_unpremultiply_8888_unit.sv =====
// Top level of the alpha un-premultiply unit for 32-bit pixels.
// Input side is a queue: drive in_pixel_in with push; an item is taken
// at a clock edge where push is high and full is low.
// Output side is a queue: while empty is low, out_pixel_out and
// out_clipped show the oldest result; it is taken when pop is high.
// cfg_we with cfg_wdata sets the alpha byte position: 0 puts alpha in
// byte 0, 1 puts alpha in byte 3. Write it only while the unit is idle.
// Each item passes an input queue, an eight-stage divider pipeline that
// produces one quotient bit per stage, and an output queue. One item
// per cycle is sustained while the receiver keeps popping.
// Reset empties both queues and the pipeline and sets alpha position 0.
// When the receiver stops popping, the output queue fills, the pipeline
// holds, the input queue fills and full rises; nothing is dropped.
module alpha_unpremultiply_8888_unit import aup_pkg::*; #(
  parameter int MID_DEPTH = MID_DEPTH_DEF,
  parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [31:0] in_pixel_in,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_pixel_out,
  output logic        out_clipped,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  logic     apos_r;
  aup_mid_t front_item;
  aup_mid_t mid_head;
  logic     mid_empty, mid_pop;
  aup_res_t res_in, res_head;
  logic     res_push, res_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      apos_r <= APOS_TRAILING;
    end else if (cfg_we) begin
      apos_r <= cfg_wdata;
    end
  end

  aup_front u_front (
    .pixel (in_pixel_in),
    .apos  (apos_r),
    .item  (front_item)
  );

  aup_queue #(
    .WIDTH ($bits(aup_mid_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (front_item),
    .full      (full),
    .pop       (mid_pop),
    .pop_data  (mid_head),
    .empty     (mid_empty)
  );

  aup_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_data  (mid_head),
    .mid_empty (mid_empty),
    .mid_pop   (mid_pop),
    .res_data  (res_in),
    .res_push  (res_push),
    .res_full  (res_full)
  );

  aup_queue #(
    .WIDTH ($bits(aup_res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_in),
    .full      (res_full),
    .pop       (pop),
    .pop_data  (res_head),
    .empty     (empty)
  );

  assign out_pixel_out = res_head.pixel;
  assign out_clipped   = res_head.clipped;

endmodule
